@@ sv/bcwr_pkg.sv @@
// shared types and constants for the cross-window binarizer
`timescale 1ns / 1ps

package bcwr_pkg;

  // geometry and storage
  localparam int MAX_WIDTH  = 1024;
  localparam int LINE_BITS  = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // register field widths
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 16;
  localparam int THR_BITS   = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THRESHOLD  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFINE_THRESHOLD = 8'd3;

  // register reset values
  localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH      = 11'd640;
  localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT     = 16'd480;
  localparam logic [THR_BITS-1:0]   RST_NOISE_THRESHOLD  = 8'd160;
  localparam logic [THR_BITS-1:0]   RST_REFINE_THRESHOLD = 8'd126;

  // white level of the binarized image
  localparam int WHITE_LEVEL = 255;

  // item modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic out_white;
    logic last_of_frame;
  } out_t;

  // cross neighbours of the output pixel, each with its in-frame flag
  typedef struct packed {
    logic [7:0] bits;
    logic [7:0] in_frame;
  } nbr_t;

endpackage

@@ sv/binarize_cross_window_refine.sv @@
// top level: thresholding plus cross-neighborhood refine over a raster stream
// Throughput: one item per cycle; input stalls while a result waits on a stalled consumer,
//   and while black pad fills the window after the last pixel of a frame under 2*W+2 pixels.
// Latency: the result for pixel o is presented the cycle after the transfer of pixel
//   o + 2*W + 2, or of the drain (or late pixel) that flushes it once the frame is in.
// Reset: counters, flags and the output valid flag clear, registers take defaults; no
//   clearing pass, stale memory entries only feed neighbours outside the frame.
`timescale 1ns / 1ps

module binarize_cross_window_refine
  import bcwr_pkg::*;
#(
  parameter int MaxWidth = MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ColW  = $clog2(MaxWidth);
  localparam int EffW  = $clog2(MaxWidth + 1);
  localparam int PosW  = EffW + 1;
  localparam int FillW = $clog2(2 * MaxWidth + 3);
  localparam int RowW  = IMG_H_BITS + 1;

  // configuration registers
  logic [IMG_W_BITS-1:0] img_w_q;
  logic [IMG_H_BITS-1:0] img_h_q;
  logic [THR_BITS-1:0]   noise_thr_q;
  logic [THR_BITS-1:0]   refine_thr_q;
  logic                  cfg_fire;
  logic                  geom_write;

  // stream control state
  logic [ColW-1:0]       in_col_q, in_col_d;
  logic [IMG_H_BITS-1:0] in_row_q, in_row_d;
  logic [ColW-1:0]       out_col_q, out_col_d;
  logic [IMG_H_BITS-1:0] out_row_q, out_row_d;
  logic [FillW-1:0]      fill_q, fill_d;
  logic                  done_q, done_d;

  // column vectors and center-row window
  logic [LINE_BITS-1:0]  vert1_q, vert2_q;
  logic [3:0]            win_q;
  logic [LINE_BITS-1:0]  col_hist;
  logic [LINE_BITS-1:0]  col_next;
  logic                  new_bit;

  // output register
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q;

  logic                  in_fire, step, emit, out_fire, pad, adv;
  logic [EffW-1:0]       eff_w;
  logic [IMG_H_BITS-1:0] eff_h;
  logic [FillW-1:0]      fill_tgt;
  logic [PosW-1:0]       in_col_p1, out_col_w;
  logic [RowW-1:0]       out_row_w, eff_h_w;
  logic                  in_col_wrap, out_col_wrap, out_last;
  nbr_t                  nbr;
  logic [3:0]            whites, cnt;
  logic [12:0]           white_sum, thr_prod;
  logic                  out_white;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign geom_write  = cfg_fire &&
                       ((cfg_index_i == CFG_IMAGE_WIDTH) || (cfg_index_i == CFG_IMAGE_HEIGHT));
  // small frame: pad the window with black until it is full, input held off
  assign pad         = done_q && (fill_q != fill_tgt);
  assign out_fire    = out_valid_q && !out_stall_i;
  assign in_stall_o  = (out_valid_q && out_stall_i) || pad;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign step        = in_fire && (done_q || (in_data_i.mode == MODE_PIXEL));
  assign adv         = step || pad;
  assign emit        = step && (done_q || (fill_q == fill_tgt));

  // effective geometry
  always_comb begin
    if (img_w_q == '0) begin
      eff_w = EffW'(1);
    end else if (32'(img_w_q) > MaxWidth) begin
      eff_w = EffW'(MaxWidth);
    end else begin
      eff_w = EffW'(img_w_q);
    end
  end
  assign eff_h    = (img_h_q == '0) ? IMG_H_BITS'(1) : img_h_q;
  assign eff_h_w  = RowW'(eff_h);
  assign fill_tgt = FillW'({eff_w, 1'b0}) + FillW'(2);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q      <= RST_IMAGE_WIDTH;
      img_h_q      <= RST_IMAGE_HEIGHT;
      noise_thr_q  <= RST_NOISE_THRESHOLD;
      refine_thr_q <= RST_REFINE_THRESHOLD;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:      img_w_q      <= cfg_data_i[IMG_W_BITS-1:0];
        CFG_IMAGE_HEIGHT:     img_h_q      <= cfg_data_i[IMG_H_BITS-1:0];
        CFG_NOISE_THRESHOLD:  noise_thr_q  <= cfg_data_i[THR_BITS-1:0];
        CFG_REFINE_THRESHOLD: refine_thr_q <= cfg_data_i[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // first pass: drain and pad steps shift in a black pixel beyond the frame
  assign new_bit  = done_q ? 1'b0 : (in_data_i.pixel_value > noise_thr_q);
  // column entry: bit 0 one row up, bit 3 four rows up
  assign col_next = {col_hist[2:0], new_bit};

  bcwr_line_store #(
    .Depth (MaxWidth),
    .AddrW (ColW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (in_col_q),
    .wdata_i (col_next),
    .raddr_i (in_col_d),
    .rdata_o (col_hist)
  );

  // neighbour gathering: vertical from the column two steps back,
  // horizontal from the center-row window
  assign out_col_w = PosW'(out_col_q);
  assign out_row_w = RowW'(out_row_q);
  always_comb begin
    nbr.bits     = {win_q[0], win_q[2], vert2_q[1], vert2_q[2],
                    col_hist[1], win_q[3], vert2_q[0], vert2_q[3]};
    nbr.in_frame = {(out_col_w + PosW'(1)) < PosW'(eff_w),
                    out_col_q != '0,
                    (out_row_w + RowW'(1)) < eff_h_w,
                    out_row_q != '0,
                    (out_col_w + PosW'(2)) < PosW'(eff_w),
                    out_col_q > ColW'(1),
                    (out_row_w + RowW'(2)) < eff_h_w,
                    out_row_q > IMG_H_BITS'(1)};
  end

  // count in-frame neighbours and whites among them
  always_comb begin
    whites = '0;
    cnt    = '0;
    for (int i = 0; i < 8; i++) begin
      whites = whites + 4'(nbr.bits[i] & nbr.in_frame[i]);
      cnt    = cnt + 4'(nbr.in_frame[i]);
    end
  end

  // floor(255*whites/cnt) > thr  <=>  255*whites >= (thr+1)*cnt
  assign white_sum = 13'(WHITE_LEVEL) * 13'(whites);
  assign thr_prod  = (13'(refine_thr_q) + 13'd1) * 13'(cnt);
  assign out_white = (cnt != '0) && (white_sum >= thr_prod);

  // position bookkeeping
  assign in_col_p1    = PosW'(in_col_q) + PosW'(1);
  assign in_col_wrap  = (in_col_p1 == PosW'(eff_w));
  assign out_col_wrap = ((out_col_w + PosW'(1)) == PosW'(eff_w));
  assign out_last     = out_col_wrap && ((out_row_w + RowW'(1)) == eff_h_w);

  // next state of counters and flags
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    fill_d    = fill_q;
    done_d    = done_q;
    if (adv) begin
      in_col_d = in_col_wrap ? '0 : in_col_p1[ColW-1:0];
      if (fill_q != fill_tgt) begin
        fill_d = fill_q + FillW'(1);
      end
      if (!done_q && in_col_wrap) begin
        if ((RowW'(in_row_q) + RowW'(1)) == eff_h_w) begin
          done_d   = 1'b1;
          in_row_d = '0;
        end else begin
          in_row_d = in_row_q + IMG_H_BITS'(1);
        end
      end
    end
    if (emit) begin
      if (out_col_wrap) begin
        out_col_d = '0;
        out_row_d = out_row_q + IMG_H_BITS'(1);
      end else begin
        out_col_d = out_col_q + ColW'(1);
      end
    end
    // frame end or geometry change restarts everything
    if ((emit && out_last) || geom_write) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      fill_d    = '0;
      done_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      fill_q    <= fill_d;
      done_q    <= done_d;
    end
  end

  // delay line of column vectors and center-row bits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vert1_q <= {col_hist[3], col_hist[2], col_hist[0], new_bit};
      vert2_q <= vert1_q;
      win_q   <= {win_q[2:0], col_hist[1]};
    end
  end

  // output register
  assign out_valid_d = emit ? 1'b1 : (out_fire ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_white     <= out_white;
      out_q.last_of_frame <= out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_q && out_stall_i))
    else $error("result produced while output register is held");

  a_out_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PosW'(out_col_q) < PosW'(eff_w))
    else $error("output column outside frame");

  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PosW'(in_col_q) < PosW'(eff_w))
    else $error("input column outside frame");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last && !geom_write) |=> (!done_q && (fill_q == '0) && (out_col_q == '0)))
    else $error("frame did not restart after last pixel");

  a_done_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (in_row_q == '0))
    else $error("input row not cleared while flushing");

endmodule

@@ sv/bcwr_line_store.sv @@
// column history memory: last four binarized rows per column, write-first read
`timescale 1ns / 1ps

module bcwr_line_store
  import bcwr_pkg::*;
#(
  parameter int Depth = MAX_WIDTH,
  parameter int AddrW = $clog2(MAX_WIDTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [LINE_BITS-1:0] wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [LINE_BITS-1:0] rdata_o
);

  logic [LINE_BITS-1:0] mem [Depth];
  logic [LINE_BITS-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, forwarding a same-edge write to the same entry
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
